// File: rtl/core/pid_speed_controller_top_assert.svh
// Assertion macros shared by the speed controller RTL.
`ifndef PID_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define PID_SPEED_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psc assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psc assertion failed");

`endif

// File: rtl/core/psc_pkg.sv
// Shared types, constants and the control program of the PID speed controller.
`default_nettype none

package psc_pkg;

  // Default width of the speed fields.
  localparam int SPEED_WIDTH = 32;

  // Internal widths.
  localparam int ERR_W      = 32;  // Q16.16 error, integral, derivative
  localparam int MUL_A_W    = 34;  // signed multiplier operand
  localparam int MUL_B_W    = 24;  // unsigned multiplier operand
  localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;
  localparam int ACC_W      = 60;  // weighted sum in Q.32
  localparam int MAG_W      = 33;  // clamped magnitude, at most 1.0 in Q.32
  localparam int CNT_W      = 12;
  localparam int PWM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int STEP_W     = 3;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MIN     = 3'd7;

  // Register reset values.
  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd655;
  localparam logic [23:0] RST_SAMPLE_RATE   = 24'd25600;
  localparam logic [30:0] RST_WINDUP_LIMIT  = 31'd6553600;
  localparam logic [11:0] RST_COUNT_MAX     = 12'd4095;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [23:0] deriv_gain;
    logic [15:0] sample_period;
    logic [23:0] sample_rate;
    logic [30:0] windup_limit;
    logic [11:0] count_max;
    logic [11:0] count_min;
  } psc_cfg_t;

  typedef enum logic [2:0] {
    A_ERR,
    A_DIFF,
    A_INTEG,
    A_DERIV,
    A_MAG
  } mul_a_sel_e;

  typedef enum logic [2:0] {
    B_PERIOD,
    B_RATE,
    B_PGAIN,
    B_IGAIN,
    B_DGAIN,
    B_CMAX
  } mul_b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic {
    JMP_NEXT,
    JMP_FINISH
  } jump_e;

  typedef struct packed {
    mul_a_sel_e a_sel;
    mul_b_sel_e b_sel;
    acc_op_e    acc_op;
    logic       integ_wr;
    logic       deriv_wr;
    logic       clamp_wr;
    logic       out_wr;
    jump_e      jump;
  } psc_ctrl_t;

  localparam psc_ctrl_t CTRL_IDLE = '{
    a_sel: A_ERR, b_sel: B_PERIOD, acc_op: ACC_HOLD, integ_wr: 1'b0,
    deriv_wr: 1'b0, clamp_wr: 1'b0, out_wr: 1'b0, jump: JMP_FINISH};

  // Control program: one word per step. A multiplier product that a step
  // uses was registered and formed by the step before it.
  function automatic psc_ctrl_t microcode(input logic [STEP_W-1:0] step);
    psc_ctrl_t w;
    w = CTRL_IDLE;
    w.jump = JMP_NEXT;
    case (step)
      3'd0: begin
        w.a_sel = A_ERR;   w.b_sel = B_PERIOD;
      end
      3'd1: begin
        w.a_sel = A_DIFF;  w.b_sel = B_RATE;   w.integ_wr = 1'b1;
      end
      3'd2: begin
        w.a_sel = A_ERR;   w.b_sel = B_PGAIN;  w.deriv_wr = 1'b1;
      end
      3'd3: begin
        w.a_sel = A_INTEG; w.b_sel = B_IGAIN;  w.acc_op = ACC_LOAD;
      end
      3'd4: begin
        w.a_sel = A_DERIV; w.b_sel = B_DGAIN;  w.acc_op = ACC_ADD;
      end
      3'd5: begin
        w.clamp_wr = 1'b1;
      end
      3'd6: begin
        w.a_sel = A_MAG;   w.b_sel = B_CMAX;
      end
      3'd7: begin
        // The scaling product is formed again so that it stays put while
        // this step holds for a full result register.
        w.a_sel = A_MAG;   w.b_sel = B_CMAX;
        w.out_wr = 1'b1;   w.jump = JMP_FINISH;
      end
      default: begin
        w = CTRL_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pid_speed_controller_top.sv
// Top level of the PID speed controller: handshakes, registers and the sequencer.
// Each accepted item runs through the eight-step control program that drives a
// single shared 34 x 24 bit multiplier; no new item is accepted until it finishes.
// The last step holds while an earlier result still waits to be taken.
// Reset (rst_ni low, asynchronous) clears the integral and previous error and
// restores every configuration register to its documented default.
`default_nettype none

module pid_speed_controller_top #(
  parameter int SPEED_WIDTH = psc_pkg::SPEED_WIDTH
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input items.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: set_speed, measured_speed, zero padding.
  input  wire  [((2*SPEED_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Result items.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata, lowest bit up: pwm_count, zero padding.
  output logic [15:0]                        m_axis_tdata,
  // tuser: out_saturated.
  output logic                               m_axis_tuser,
  // Configuration write port.
  input  wire                                cfg_we_i,
  input  wire  [psc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [psc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

`include "pid_speed_controller_top_assert.svh"

  localparam int IN_W = ((2*SPEED_WIDTH+7)/8)*8;

  psc_pkg::psc_cfg_t  cfg_q;
  psc_pkg::psc_ctrl_t rom_word;
  psc_pkg::psc_ctrl_t ctrl;

  logic                        busy_q;
  logic [psc_pkg::STEP_W-1:0]  step_q;
  logic                        m_valid_q;
  logic                        accept;
  logic                        out_full;
  logic                        finish;
  logic [psc_pkg::PWM_W-1:0]   pwm;
  logic                        sat;
  logic [IN_W-1:0]             in_data;

  // One item is worked on at a time; the result register lets the next item
  // enter while the previous result still waits downstream.
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_full      = m_valid_q && !m_axis_tready;
  assign in_data       = s_axis_tdata;

  // Control word of the current step; idle word while no item is in work.
  // The final step writes the result only once the result register is free,
  // otherwise the program stays on that step.
  always_comb begin
    rom_word = psc_pkg::microcode(step_q);
    ctrl     = busy_q ? rom_word : psc_pkg::CTRL_IDLE;
    if (out_full) begin
      ctrl.out_wr = 1'b0;
    end
    finish = busy_q && (rom_word.jump == psc_pkg::JMP_FINISH) && !out_full;
  end

  // Step counter and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (rom_word.jump == psc_pkg::JMP_NEXT) begin
          step_q <= step_q + 1'b1;
        end else if (finish) begin
          busy_q <= 1'b0;
        end
      end
      if (ctrl.out_wr) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= '0;
      cfg_q.integ_gain    <= '0;
      cfg_q.deriv_gain    <= '0;
      cfg_q.sample_period <= psc_pkg::RST_SAMPLE_PERIOD;
      cfg_q.sample_rate   <= psc_pkg::RST_SAMPLE_RATE;
      cfg_q.windup_limit  <= psc_pkg::RST_WINDUP_LIMIT;
      cfg_q.count_max     <= psc_pkg::RST_COUNT_MAX;
      cfg_q.count_min     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psc_pkg::REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i[23:0];
        psc_pkg::REG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_wdata_i[23:0];
        psc_pkg::REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_wdata_i[23:0];
        psc_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_wdata_i[15:0];
        psc_pkg::REG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg_wdata_i[23:0];
        psc_pkg::REG_WINDUP_LIMIT:  cfg_q.windup_limit  <= cfg_wdata_i[30:0];
        psc_pkg::REG_COUNT_MAX:     cfg_q.count_max     <= cfg_wdata_i[11:0];
        psc_pkg::REG_COUNT_MIN:     cfg_q.count_min     <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  psc_datapath #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .target_i   (in_data[SPEED_WIDTH-1:0]),
    .measured_i (in_data[2*SPEED_WIDTH-1:SPEED_WIDTH]),
    .cfg_i      (cfg_q),
    .ctrl_i     (ctrl),
    .pwm_o      (pwm),
    .sat_o      (sat)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(16-psc_pkg::PWM_W){1'b0}}, pwm};
  assign m_axis_tuser  = sat;

  `PSC_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept,
    busy_q && (step_q == '0))
  `PSC_ASSERT_IMP(a_result_from_program, clk_i, rst_ni, $rose(m_valid_q),
    $past(busy_q) && ($past(step_q) == psc_pkg::STEP_LAST))
  `PSC_ASSERT_NEXT(a_hold_when_full, clk_i, rst_ni,
    busy_q && (rom_word.jump == psc_pkg::JMP_FINISH) && out_full,
    busy_q && m_valid_q && (step_q == psc_pkg::STEP_LAST))

endmodule

`default_nettype wire

// File: rtl/core/psc_datapath.sv
// Datapath of the PID speed controller: shared multiplier, accumulator and state.
`default_nettype none

module psc_datapath #(
  parameter int SPEED_WIDTH = psc_pkg::SPEED_WIDTH
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           load_i,
  input  wire  [SPEED_WIDTH-1:0]        target_i,
  input  wire  [SPEED_WIDTH-1:0]        measured_i,
  input  psc_pkg::psc_cfg_t             cfg_i,
  input  psc_pkg::psc_ctrl_t            ctrl_i,
  output logic [psc_pkg::PWM_W-1:0]     pwm_o,
  output logic                          sat_o
);

`include "pid_speed_controller_top_assert.svh"

  localparam int DW = (SPEED_WIDTH + 1 > 33) ? SPEED_WIDTH + 1 : 33;
  localparam int EW = psc_pkg::ERR_W;
  localparam int AW = psc_pkg::MUL_A_W;
  localparam int BW = psc_pkg::MUL_B_W;
  localparam int PW = psc_pkg::PROD_W;
  localparam int CW = psc_pkg::ACC_W;
  localparam int MW = psc_pkg::MAG_W;
  localparam int NW = psc_pkg::CNT_W;
  localparam int IW = PW - 16 + 1;   // integral sum width
  localparam int DSW = PW - 8;       // shifted derivative width

  localparam logic signed [DW-1:0]  ERR_MAX  = DW'(64'sh7FFF_FFFF);
  localparam logic signed [DW-1:0]  ERR_MIN  = DW'(-64'sh8000_0000);
  localparam logic signed [DSW-1:0] DER_MAX  = DSW'(64'sh7FFF_FFFF);
  localparam logic signed [DSW-1:0] DER_MIN  = DSW'(-64'sh8000_0000);
  localparam logic signed [CW-1:0]  SUM_ONE  = CW'(64'sh1_0000_0000);
  localparam logic [MW-1:0]         MAG_ONE  = MW'(64'h1_0000_0000);

  logic signed [EW-1:0] err_q, err_d;
  logic signed [EW-1:0] prev_q;
  logic signed [EW-1:0] integ_q, integ_d;
  logic signed [EW-1:0] deriv_q, deriv_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [CW-1:0] acc_q, acc_d;
  logic [MW-1:0]        mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic                 sat_q, sat_d;
  logic [psc_pkg::PWM_W-1:0] pwm_q, pwm_d;
  logic                 sat_out_q;

  logic signed [DW-1:0] diff_in;
  logic signed [EW:0]   diff_err;
  logic signed [AW-1:0] mul_a;
  logic [BW-1:0]        mul_b;
  logic signed [IW-1:0] isum, ilim;
  logic signed [DSW-1:0] dsh;
  logic signed [CW-1:0] prod_ext, sum;
  logic signed [CW-1:0] sum_neg;
  logic [NW-1:0]        cnt_raw, cnt;
  logic signed [EW:0]   lim_s;

  // Error of the incoming item, saturated to the Q16.16 range.
  always_comb begin
    diff_in = $signed({{(DW-SPEED_WIDTH){target_i[SPEED_WIDTH-1]}}, target_i})
            - $signed({{(DW-SPEED_WIDTH){measured_i[SPEED_WIDTH-1]}}, measured_i});
    if (diff_in > ERR_MAX) begin
      err_d = EW'(ERR_MAX);
    end else if (diff_in < ERR_MIN) begin
      err_d = EW'(ERR_MIN);
    end else begin
      err_d = diff_in[EW-1:0];
    end
  end

  // Shared multiplier operands.
  always_comb begin
    diff_err = $signed({err_q[EW-1], err_q}) - $signed({prev_q[EW-1], prev_q});
    case (ctrl_i.a_sel)
      psc_pkg::A_ERR:   mul_a = {{(AW-EW){err_q[EW-1]}}, err_q};
      psc_pkg::A_DIFF:  mul_a = {{(AW-EW-1){diff_err[EW]}}, diff_err};
      psc_pkg::A_INTEG: mul_a = {{(AW-EW){integ_q[EW-1]}}, integ_q};
      psc_pkg::A_DERIV: mul_a = {{(AW-EW){deriv_q[EW-1]}}, deriv_q};
      psc_pkg::A_MAG:   mul_a = {{(AW-MW){1'b0}}, mag_q};
      default:          mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      psc_pkg::B_PERIOD: mul_b = BW'(cfg_i.sample_period);
      psc_pkg::B_RATE:   mul_b = cfg_i.sample_rate;
      psc_pkg::B_PGAIN:  mul_b = cfg_i.prop_gain;
      psc_pkg::B_IGAIN:  mul_b = cfg_i.integ_gain;
      psc_pkg::B_DGAIN:  mul_b = cfg_i.deriv_gain;
      psc_pkg::B_CMAX:   mul_b = BW'(cfg_i.count_max);
      default:           mul_b = '0;
    endcase
    prod_d = mul_a * $signed({1'b0, mul_b});
  end

  // Integral update: floor of the Q16.32 increment, then the windup clamp.
  always_comb begin
    isum = $signed({integ_q[EW-1], {(IW-EW-1){integ_q[EW-1]}}, integ_q})
         + $signed({prod_q[PW-1], prod_q[PW-1:16]});
    ilim = $signed(IW'(cfg_i.windup_limit));
    if (isum > ilim) begin
      integ_d = ilim[EW-1:0];
    end else if (isum < -ilim) begin
      integ_d = EW'(-ilim);
    end else begin
      integ_d = isum[EW-1:0];
    end
  end

  // Derivative: floor of the Q.24 product to Q16.16, saturated.
  always_comb begin
    dsh = prod_q[PW-1:8];
    if (dsh > DER_MAX) begin
      deriv_d = EW'(DER_MAX);
    end else if (dsh < DER_MIN) begin
      deriv_d = EW'(DER_MIN);
    end else begin
      deriv_d = dsh[EW-1:0];
    end
  end

  // Weighted sum, clamp to plus or minus 1.0 and magnitude.
  always_comb begin
    prod_ext = $signed({{(CW-PW){prod_q[PW-1]}}, prod_q});
    case (ctrl_i.acc_op)
      psc_pkg::ACC_LOAD: acc_d = prod_ext;
      psc_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      default:           acc_d = acc_q;
    endcase
    sum     = acc_q + prod_ext;
    sum_neg = -sum;
    if (sum > SUM_ONE) begin
      mag_d = MAG_ONE;
      neg_d = 1'b0;
      sat_d = 1'b1;
    end else if (sum < -SUM_ONE) begin
      mag_d = MAG_ONE;
      neg_d = 1'b1;
      sat_d = 1'b1;
    end else begin
      neg_d = sum[CW-1];
      mag_d = sum[CW-1] ? sum_neg[MW-1:0] : sum[MW-1:0];
      sat_d = 1'b0;
    end
  end

  // Scaled count with the dead zone applied to nonzero values.
  always_comb begin
    cnt_raw = prod_q[32 +: NW];
    if ((cnt_raw != '0) && (cnt_raw < cfg_i.count_min)) begin
      cnt = cfg_i.count_min;
    end else begin
      cnt = cnt_raw;
    end
    pwm_d = neg_q ? (-{1'b0, cnt}) : {1'b0, cnt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      if (ctrl_i.integ_wr) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.out_wr) begin
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (load_i) begin
      err_q <= err_d;
    end
    if (ctrl_i.deriv_wr) begin
      deriv_q <= deriv_d;
    end
    if (ctrl_i.clamp_wr) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      sat_q <= sat_d;
    end
    if (ctrl_i.out_wr) begin
      pwm_q     <= pwm_d;
      sat_out_q <= sat_q;
    end
  end

  assign pwm_o = pwm_q;
  assign sat_o = sat_out_q;
  assign lim_s = $signed({2'b00, cfg_i.windup_limit});

  `PSC_ASSERT_NEXT(a_integ_bound, clk_i, rst_ni, ctrl_i.integ_wr,
    (integ_q <= $past(lim_s)) && (integ_q >= -$past(lim_s)))
  `PSC_ASSERT_NEXT(a_mag_bound, clk_i, rst_ni, ctrl_i.clamp_wr,
    (mag_q <= MAG_ONE) && (!sat_q || (mag_q == MAG_ONE)))
  `PSC_ASSERT_NEXT(a_prev_follows, clk_i, rst_ni, ctrl_i.out_wr, prev_q == err_q)

endmodule

`default_nettype wire
